@@ sv/c2p_pkg.sv @@
// Shared types, constants and the arctangent table function for the complex-to-polar unit.
`timescale 1ns / 1ps
`default_nettype none

package c2p_pkg;

    // Sample and result field widths.
    localparam int C_SAMPLE_W   = 16;
    localparam int C_RESULT_W   = 16;

    // Fraction bits added below the sample before the micro-rotations.
    localparam int C_GUARD      = 8;

    // Datapath widths: x and y need two bits of headroom for the quarter
    // turn and the CORDIC gain; the angle is radians in Q21.
    localparam int C_XW         = C_SAMPLE_W + C_GUARD + 2;
    localparam int C_ZW         = 24;

    // Gain compensation and the product that carries it.
    localparam int C_GAIN_W     = 17;
    localparam int C_PW         = C_XW + C_GAIN_W;
    localparam int C_GAIN_INV   = 39797;
    localparam int C_MAG_SHIFT  = 24;

    // Angle constants.
    localparam int C_ATAN_ONE   = 1647099;
    localparam int C_QUARTER    = 3294199;
    localparam int C_PI_OUT     = 25736;
    localparam int C_HALF_PI    = 12868;
    localparam int C_PH_SHIFT   = 8;

    // Default number of micro-rotation cells.
    localparam int C_STEPS_DEF  = 16;

    // One incoming sample.
    typedef struct packed {
        logic signed [C_SAMPLE_W-1:0] real_part;
        logic signed [C_SAMPLE_W-1:0] imag_part;
    } t_c2p_in;

    // One polar result.
    typedef struct packed {
        logic        [C_RESULT_W-1:0] magnitude;
        logic signed [C_RESULT_W-1:0] phase;
    } t_c2p_out;

    // What one cell hands to the next.
    typedef struct packed {
        logic signed [C_XW-1:0] x;
        logic signed [C_XW-1:0] y;
        logic signed [C_ZW-1:0] z;
        logic                   bypass;
        t_c2p_out               bypass_res;
    } t_c2p_stage;

    // atan(2^-idx) in Q21, from the alternating power series at 2^-60
    // resolution, rounded half up. Evaluated only at elaboration.
    function automatic int unsigned atan_q21(input int unsigned idx);
        logic [63:0] acc;
        logic [63:0] term;
        int unsigned n;
        logic        add;
        acc = 64'd0;
        add = 1'b1;
        if (idx == 0) begin
            return C_ATAN_ONE;
        end
        for (n = 1; n <= 59; n += 2) begin
            if (idx * n <= 60) begin
                term = (64'd1 << (60 - idx * n)) / 64'(n);
                if (add) begin
                    acc = acc + term;
                end else begin
                    acc = acc - term;
                end
                add = ~add;
            end
        end
        return 32'((acc + (64'd1 << 38)) >> 39);
    endfunction

endpackage

`default_nettype wire

@@ sv/c2p_prep.sv @@
// Input stage: special-case detection and the quarter-turn pre-rotation into the right half plane.
`timescale 1ns / 1ps
`default_nettype none

module c2p_prep (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire c2p_pkg::t_c2p_in   i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output c2p_pkg::t_c2p_stage     o_data
);

    localparam int XW = c2p_pkg::C_XW;
    localparam int ZW = c2p_pkg::C_ZW;
    localparam int RW = c2p_pkg::C_RESULT_W;

    logic                 r_valid;
    c2p_pkg::t_c2p_stage  r_data;
    c2p_pkg::t_c2p_stage  n_data;

    logic signed [XW-1:0] re_ext;
    logic signed [XW-1:0] im_ext;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic                 re_zero;
    logic                 im_zero;

    // Sign-extend, scale up by the guard bits and look for the exact cases.
    always_comb begin
        re_ext  = XW'(i_data.real_part);
        im_ext  = XW'(i_data.imag_part);
        x0      = re_ext <<< c2p_pkg::C_GUARD;
        y0      = im_ext <<< c2p_pkg::C_GUARD;
        re_zero = (i_data.real_part == '0);
        im_zero = (i_data.imag_part == '0);
    end

    // Build the first cell's operands.
    always_comb begin
        n_data        = '0;
        n_data.x      = x0;
        n_data.y      = y0;
        n_data.z      = '0;
        n_data.bypass = re_zero || im_zero;

        // A negative real part is turned a quarter turn toward the right half.
        if (x0 < 0) begin
            if (y0 > 0) begin
                n_data.x = y0;
                n_data.y = -x0;
                n_data.z = ZW'(c2p_pkg::C_QUARTER);
            end else begin
                n_data.x = -y0;
                n_data.y = x0;
                n_data.z = -ZW'(c2p_pkg::C_QUARTER);
            end
        end

        // On an axis the answer is exact and skips the rotations.
        if (im_zero) begin
            n_data.bypass_res.magnitude = RW'(re_ext < 0 ? -re_ext : re_ext);
            n_data.bypass_res.phase     = (re_ext < 0) ? RW'(c2p_pkg::C_PI_OUT) : '0;
        end else begin
            n_data.bypass_res.magnitude = RW'(im_ext < 0 ? -im_ext : im_ext);
            n_data.bypass_res.phase     = (im_ext > 0) ? RW'(c2p_pkg::C_HALF_PI)
                                                       : -RW'(c2p_pkg::C_HALF_PI);
        end
    end

    // The stage loads whenever it is empty or its content moves on.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ sv/c2p_cell.sv @@
// One CORDIC vectoring micro-rotation cell with its own pipeline register.
`timescale 1ns / 1ps
`default_nettype none

module c2p_cell #(
    parameter int STEP = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire c2p_pkg::t_c2p_stage  i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output c2p_pkg::t_c2p_stage       o_data
);

    localparam int XW = c2p_pkg::C_XW;
    localparam int ZW = c2p_pkg::C_ZW;
    localparam logic signed [ZW-1:0] ATAN = ZW'(c2p_pkg::atan_q21(STEP));

    logic                 r_valid;
    c2p_pkg::t_c2p_stage  r_data;
    c2p_pkg::t_c2p_stage  n_data;

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    // Rotate toward the real axis; the sign of y picks the direction.
    always_comb begin
        xs     = i_data.x >>> STEP;
        ys     = i_data.y >>> STEP;
        n_data = i_data;
        if (!i_data.y[XW-1]) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + ATAN;
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - ATAN;
        end
    end

    // Per-cell handshake: load when empty or when the next cell takes the content.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ sv/c2p_post.sv @@
// Output stages: gain-compensation multiply, then rounding, clamping and the special-case select.
`timescale 1ns / 1ps
`default_nettype none

module c2p_post (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire c2p_pkg::t_c2p_stage  i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output c2p_pkg::t_c2p_out         o_data
);

    localparam int PW = c2p_pkg::C_PW;
    localparam int ZW = c2p_pkg::C_ZW;
    localparam int RW = c2p_pkg::C_RESULT_W;
    localparam int MW = PW - c2p_pkg::C_MAG_SHIFT;
    localparam int HW = ZW + 1 - c2p_pkg::C_PH_SHIFT;

    localparam logic signed [PW-1:0] GAIN    = PW'(c2p_pkg::C_GAIN_INV);
    localparam logic signed [PW-1:0] MAG_RND = PW'(1) <<< (c2p_pkg::C_MAG_SHIFT - 1);
    localparam logic signed [ZW:0]   PH_RND  = (ZW + 1)'(1) <<< (c2p_pkg::C_PH_SHIFT - 1);
    localparam logic signed [MW-1:0] MAG_MAX = MW'((1 << RW) - 1);
    localparam logic signed [HW-1:0] PH_MAX  = HW'(c2p_pkg::C_PI_OUT);

    // Product stage registers.
    logic                    r_a_valid;
    logic signed [PW-1:0]    r_a_prod;
    logic signed [ZW-1:0]    r_a_z;
    logic                    r_a_bypass;
    c2p_pkg::t_c2p_out       r_a_bypass_res;
    logic                    a_ready;

    // Output register.
    logic                    r_b_valid;
    c2p_pkg::t_c2p_out       r_b_data;
    c2p_pkg::t_c2p_out       n_b_data;

    logic signed [PW-1:0]    mag_sum;
    logic signed [MW-1:0]    mag_full;
    logic signed [ZW:0]      ph_sum;
    logic signed [HW-1:0]    ph_full;

    // Multiply the final x by the inverse CORDIC gain.
    assign o_ready = !r_a_valid || a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a_prod       <= PW'(i_data.x) * GAIN;
            r_a_z          <= i_data.z;
            r_a_bypass     <= i_data.bypass;
            r_a_bypass_res <= i_data.bypass_res;
        end
    end

    // Round both results, clamp them, and pick the exact answer on an axis.
    always_comb begin
        mag_sum  = r_a_prod + MAG_RND;
        mag_full = mag_sum[PW-1:c2p_pkg::C_MAG_SHIFT];
        ph_sum   = {r_a_z[ZW-1], r_a_z} + PH_RND;
        ph_full  = ph_sum[ZW:c2p_pkg::C_PH_SHIFT];

        if (mag_full < 0) begin
            n_b_data.magnitude = '0;
        end else if (mag_full > MAG_MAX) begin
            n_b_data.magnitude = RW'(MAG_MAX);
        end else begin
            n_b_data.magnitude = RW'(mag_full);
        end

        if (ph_full > PH_MAX) begin
            n_b_data.phase = RW'(PH_MAX);
        end else if (ph_full < -PH_MAX) begin
            n_b_data.phase = RW'(-PH_MAX);
        end else begin
            n_b_data.phase = RW'(ph_full);
        end

        if (r_a_bypass) begin
            n_b_data = r_a_bypass_res;
        end
    end

    assign a_ready = !r_b_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && r_a_valid) begin
            r_b_data <= n_b_data;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule

`default_nettype wire

@@ sv/complex_to_polar.sv @@
// Top level of the pipelined CORDIC complex-to-polar converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts one complex sample per clock into magnitude and phase while the output
// side does not stall. Each request passes through an input stage, a row of
// ROTATION_STEPS micro-rotation cells and two output stages, each registered.
// Every stage holds its own item and frees itself as soon as the next stage
// takes it, so a stall on the output fills the pipeline one stage at a time
// before input ready drops, and a waiting result never blocks a new request
// while an empty stage remains.
// Magnitude is unsigned in the input scale, gain-compensated and rounded; phase
// is signed radians times 8192 with atan2 quadrant rules. Zero input gives phase
// zero, and a negative real sample on the axis gives plus pi.

module complex_to_polar #(
    parameter int ROTATION_STEPS = c2p_pkg::C_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire c2p_pkg::t_c2p_in   i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output c2p_pkg::t_c2p_out       o_out_data
);

    c2p_pkg::t_c2p_stage w_data  [ROTATION_STEPS+1];
    logic                w_valid [ROTATION_STEPS+1];
    logic                w_ready [ROTATION_STEPS+1];

    // Input stage.
    c2p_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    // Row of micro-rotation cells.
    for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_cell
        c2p_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // Gain compensation, rounding and output register.
    c2p_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[ROTATION_STEPS]),
        .o_ready (w_ready[ROTATION_STEPS]),
        .i_data  (w_data[ROTATION_STEPS]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // An accepted request always lands in the input stage.
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> w_valid[0])
        else $error("accepted request did not reach the input stage");

    // Input ready only drops while the input stage holds an item.
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_valid[0])
        else $error("input stalled with an empty input stage");

    // A delivered phase stays within plus or minus pi.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.phase <= 16'sd25736) &&
                        (o_out_data.phase >= -16'sd25736))
        else $error("phase out of range");
`endif

endmodule

`default_nettype wire

@@ tb/sv/complex_to_polar_tb.sv @@
// Self-checking testbench for the pipelined complex-to-polar converter.
`timescale 1ns / 1ps

module complex_to_polar_tb;

    localparam int STEPS        = c2p_pkg::C_STEPS_DEF;
    localparam int PIPE_LATENCY = STEPS + 3;
    localparam int LONG_STALL   = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_CORNERS  = 22;

    // Corner samples: axes, extremes of both fields, every quadrant, near-pi.
    localparam int CORNER_RE [NUM_CORNERS] = '{
        0, 32767, -32768, -1, 0, 0, 0, 0, 32767, -32768, -32768,
        32767, -1, -1, 1, 1, -32768, -32768, 100, -5, 1, -32767
    };
    localparam int CORNER_IM [NUM_CORNERS] = '{
        0, 0, 0, 0, 32767, -32768, 1, -1, 32767, -32768, 32767,
        -32768, 1, -1, 1, -1, 1, -1, -1, 3, 32767, 32767
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    c2p_pkg::t_c2p_in   in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    c2p_pkg::t_c2p_out  out_data;

    // Polar results still owed by the block, oldest first.
    c2p_pkg::t_c2p_out  expected_polar [$];
    c2p_pkg::t_c2p_out  oldest_polar;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_requests = 0;
    int stall_served   = 0;
    int hold_left      = 0;

    complex_to_polar #(
        .ROTATION_STEPS (STEPS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #10 clk = ~clk;

    // Arctangent of 2^-step in Q21, summed from the alternating series.
    function automatic longint atan_pow2(input int step);
        longint unsigned sum;
        longint unsigned term;
        int              n;
        bit              add;
        sum = 0;
        add = 1'b1;
        if (step == 0) begin
            return c2p_pkg::C_ATAN_ONE;
        end
        for (n = 1; step * n <= 60; n += 2) begin
            term = (64'd1 << (60 - step * n)) / 64'(n);
            if (add) begin
                sum = sum + term;
            end else begin
                sum = sum - term;
            end
            add = ~add;
        end
        return longint'((sum + (64'd1 << 38)) >> 39);
    endfunction

    // Magnitude and phase the block must produce for one sample.
    function automatic c2p_pkg::t_c2p_out polar_of(input c2p_pkg::t_c2p_in s);
        c2p_pkg::t_c2p_out res;
        longint   re, im, x, y, z, xs, ys, t, m, ph;
        int       i;
        re = longint'(s.real_part);
        im = longint'(s.imag_part);
        if (im == 0) begin
            m = (re < 0) ? -re : re;
            res.magnitude = m[15:0];
            res.phase     = (re < 0) ? 16'(c2p_pkg::C_PI_OUT) : 16'd0;
            return res;
        end
        if (re == 0) begin
            m = (im < 0) ? -im : im;
            res.magnitude = m[15:0];
            res.phase     = (im > 0) ? 16'(c2p_pkg::C_HALF_PI) : 16'(-c2p_pkg::C_HALF_PI);
            return res;
        end

        // Bring the vector into the right half plane with a quarter turn.
        x = re <<< c2p_pkg::C_GUARD;
        y = im <<< c2p_pkg::C_GUARD;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y > 0) begin
                x = y;
                y = -t;
                z = c2p_pkg::C_QUARTER;
            end else begin
                x = -y;
                y = t;
                z = -c2p_pkg::C_QUARTER;
            end
        end

        // Vectoring micro-rotations drive y toward zero.
        for (i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_pow2(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_pow2(i);
            end
        end

        m = (x * c2p_pkg::C_GAIN_INV + (64'sd1 <<< 23)) >>> c2p_pkg::C_MAG_SHIFT;
        if (m < 0) begin
            m = 0;
        end else if (m > 65535) begin
            m = 65535;
        end
        ph = (z + 128) >>> c2p_pkg::C_PH_SHIFT;
        if (ph > c2p_pkg::C_PI_OUT) begin
            ph = c2p_pkg::C_PI_OUT;
        end else if (ph < -c2p_pkg::C_PI_OUT) begin
            ph = -c2p_pkg::C_PI_OUT;
        end
        res.magnitude = m[15:0];
        res.phase     = ph[15:0];
        return res;
    endfunction

    function automatic c2p_pkg::t_c2p_in pack_sample(input int re, input int im);
        c2p_pkg::t_c2p_in s;
        s.real_part = 16'(re);
        s.imag_part = 16'(im);
        return s;
    endfunction

    // Random sample, weighted toward axes, tiny values and the extremes.
    function automatic c2p_pkg::t_c2p_in random_sample();
        c2p_pkg::t_c2p_in s;
        int      pick;
        int      ext [6];
        ext = '{-32768, -32767, -1, 0, 1, 32767};
        s = c2p_pkg::t_c2p_in'($urandom);
        pick = $urandom_range(9);
        case (pick)
            0: begin
                s.real_part = '0;
            end
            1: begin
                s.imag_part = '0;
            end
            2: begin
                s = pack_sample($urandom_range(16) - 8, $urandom_range(16) - 8);
            end
            3: begin
                s = pack_sample(ext[$urandom_range(5)], ext[$urandom_range(5)]);
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Offer one request, starting at a falling edge, and log its expected result
    // when it is accepted. Returns at the next falling edge with valid still high.
    task automatic send_sample(input c2p_pkg::t_c2p_in s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        expected_polar.push_back(polar_of(s));
        @(negedge clk);
    endtask

    // Park the sender until every outstanding result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_polar.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic test_corner_samples();
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < NUM_CORNERS; k++) begin
            send_sample(pack_sample(CORNER_RE[k], CORNER_IM[k]));
        end
        drain_results();
        repeat (5) @(negedge clk);
    endtask

    // Hold the output off long enough to fill the pipeline and stall the input.
    task automatic test_output_stall(input int count);
        int k;
        in_valid      <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        stall_requests++;
        @(negedge clk);
        for (k = 0; k < count; k++) begin
            send_sample(random_sample());
        end
        drain_results();
    endtask

    task automatic test_random_samples(input int count, input int send_pct,
                                       input int recv_pct);
        int k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (k = 0; k < count; k++) begin
            send_sample(random_sample());
        end
    endtask

    // Output side: random idling, plus a long hold-off when one is requested.
    always @(negedge clk) begin
        if (stall_requests != stall_served) begin
            stall_served = stall_requests;
            hold_left    = LONG_STALL;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_polar.size() == 0) begin
                report_mismatch($sformatf("unexpected result mag=%0d phase=%0d",
                                          out_data.magnitude, out_data.phase));
            end else begin
                oldest_polar = expected_polar.pop_front();
                if (out_data.magnitude !== oldest_polar.magnitude) begin
                    report_mismatch($sformatf("magnitude %0d, expected %0d",
                                              out_data.magnitude,
                                              oldest_polar.magnitude));
                end
                if (out_data.phase !== oldest_polar.phase) begin
                    report_mismatch($sformatf("phase %0d, expected %0d",
                                              out_data.phase, oldest_polar.phase));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_corner_samples();
        test_random_samples(400, 10, 47);
        test_output_stall(80);
        test_random_samples(400, 47, 10);
        test_random_samples(400, 0, 0);

        drain_results();
        repeat (PIPE_LATENCY + 10) @(negedge clk);
        if (expected_polar.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_polar.size()));
        end
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
